FILE: hw/rtl/spi_baud_prescaler_search_top_defines.svh
// Assertion macros shared by the checker.
`ifndef SPI_BAUD_PRESCALER_SEARCH_TOP_DEFINES_SVH
`define SPI_BAUD_PRESCALER_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset
`define SBPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbps assertion failed");

// Next-cycle implication, clocked on clk, off during reset
`define SBPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbps assertion failed");

`endif

FILE: hw/rtl/sbps_pkg.sv
package sbps_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned DivW     = 18;  // largest divisor 32768*7 fits
  localparam int unsigned SclIdxW  = 4;
  localparam int unsigned PscIdxW  = 2;
  localparam int unsigned CandW    = SclIdxW + PscIdxW;
  localparam int unsigned BitCntW  = 5;
  localparam int unsigned BaudW    = 31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_CMP,
    ST_FIN
  } state_t;

  function automatic logic [15:0] scaler_f(input logic [SclIdxW-1:0] idx);
    logic [15:0] v;
    case (idx)
      4'd0:    v = 16'd2;
      4'd1:    v = 16'd4;
      4'd2:    v = 16'd6;
      4'd3:    v = 16'd8;
      default: v = 16'd1 << idx;   // 16 .. 32768
    endcase
    return v;
  endfunction

  function automatic logic [2:0] prescaler_f(input logic [PscIdxW-1:0] idx);
    logic [2:0] v;
    case (idx)
      2'd0:    v = 3'd2;
      2'd1:    v = 3'd3;
      2'd2:    v = 3'd5;
      default: v = 3'd7;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/spi_baud_prescaler_search_top.sv
// Each accepted item is searched over 64 candidates (scaler/prescaler pairs), one after another.
// No new item is taken until the search is done; the search uses the single shared serial divider,
// one quotient bit per cycle, 32 bits for each scaler/prescaler pair.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_valid.
module spi_baud_prescaler_search_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_module_clock,
  input  logic [31:0] in_target_baud,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_scaler_index,
  output logic [1:0]  out_prescaler_index,
  output logic [30:0] out_achieved_baud,
  output logic        out_exact_match
);

  sbps_pkg::state_t state_r, state_nxt;

  logic [sbps_pkg::DataW-1:0]   clk_r, tgt_r;
  logic [sbps_pkg::CandW-1:0]   cand_r, cand_nxt;
  logic [sbps_pkg::DivW-1:0]    div_r, div_nxt;
  logic [sbps_pkg::DivW-1:0]    rem_r, rem_nxt;
  logic [sbps_pkg::DataW-1:0]   quo_r, quo_nxt;
  logic [sbps_pkg::BitCntW-1:0] bcnt_r, bcnt_nxt;
  logic                         have_r, have_nxt;
  logic [sbps_pkg::DataW-1:0]   best_diff_r, best_diff_nxt;
  logic [sbps_pkg::DataW-1:0]   best_q_r, best_q_nxt;
  logic [sbps_pkg::CandW-1:0]   best_cand_r, best_cand_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [sbps_pkg::SclIdxW-1:0] out_scl_r, out_scl_nxt;
  logic [sbps_pkg::PscIdxW-1:0] out_psc_r, out_psc_nxt;
  logic [sbps_pkg::BaudW-1:0]   out_baud_r, out_baud_nxt;
  logic                         out_exact_r, out_exact_nxt;

  logic                         in_acc;
  logic [sbps_pkg::DivW:0]      trial;
  logic [sbps_pkg::DivW:0]      trial_sub;
  logic [sbps_pkg::DataW-1:0]   diff;
  logic [15:0]                  scl_val;
  logic [2:0]                   psc_val;

  assign in_ready = (state_r == sbps_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign scl_val = sbps_pkg::scaler_f(cand_r[sbps_pkg::CandW-1:sbps_pkg::PscIdxW]);
  assign psc_val = sbps_pkg::prescaler_f(cand_r[sbps_pkg::PscIdxW-1:0]);

  // restoring division step: shift in next dividend bit, try subtract
  assign trial     = {rem_r, quo_r[sbps_pkg::DataW-1]};
  assign trial_sub = trial - {1'b0, div_r};

  assign diff = (quo_r >= tgt_r) ? (quo_r - tgt_r) : (tgt_r - quo_r);

  always_comb begin
    state_nxt     = state_r;
    cand_nxt      = cand_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    bcnt_nxt      = bcnt_r;
    have_nxt      = have_r;
    best_diff_nxt = best_diff_r;
    best_q_nxt    = best_q_r;
    best_cand_nxt = best_cand_r;
    out_valid_nxt = out_valid_r;
    out_scl_nxt   = out_scl_r;
    out_psc_nxt   = out_psc_r;
    out_baud_nxt  = out_baud_r;
    out_exact_nxt = out_exact_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      sbps_pkg::ST_IDLE: begin
        if (in_acc) begin
          cand_nxt  = '0;
          have_nxt  = 1'b0;
          state_nxt = sbps_pkg::ST_LOAD;
        end
      end
      sbps_pkg::ST_LOAD: begin
        div_nxt   = sbps_pkg::DivW'(scl_val) * sbps_pkg::DivW'(psc_val);
        rem_nxt   = '0;
        quo_nxt   = clk_r;
        bcnt_nxt  = '0;
        state_nxt = sbps_pkg::ST_DIV;
      end
      sbps_pkg::ST_DIV: begin
        if (!trial_sub[sbps_pkg::DivW]) begin
          rem_nxt = trial_sub[sbps_pkg::DivW-1:0];
          quo_nxt = {quo_r[sbps_pkg::DataW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[sbps_pkg::DivW-1:0];
          quo_nxt = {quo_r[sbps_pkg::DataW-2:0], 1'b0};
        end
        bcnt_nxt = bcnt_r + 1'b1;
        if (bcnt_r == '1) begin
          state_nxt = sbps_pkg::ST_CMP;
        end
      end
      sbps_pkg::ST_CMP: begin
        // strict compare: earliest candidate wins a tie
        if (!have_r || (diff < best_diff_r)) begin
          have_nxt      = 1'b1;
          best_diff_nxt = diff;
          best_q_nxt    = quo_r;
          best_cand_nxt = cand_r;
        end
        if (cand_r == '1) begin
          state_nxt = sbps_pkg::ST_FIN;
        end else begin
          cand_nxt  = cand_r + 1'b1;
          state_nxt = sbps_pkg::ST_LOAD;
        end
      end
      sbps_pkg::ST_FIN: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_scl_nxt   = best_cand_r[sbps_pkg::CandW-1:sbps_pkg::PscIdxW];
          out_psc_nxt   = best_cand_r[sbps_pkg::PscIdxW-1:0];
          out_baud_nxt  = best_q_r[sbps_pkg::BaudW-1:0];
          out_exact_nxt = (best_diff_r == '0);
          state_nxt     = sbps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sbps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbps_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      have_r      <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      clk_r <= in_module_clock;
      tgt_r <= in_target_baud;
    end
    cand_r      <= cand_nxt;
    div_r       <= div_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    bcnt_r      <= bcnt_nxt;
    best_diff_r <= best_diff_nxt;
    best_q_r    <= best_q_nxt;
    best_cand_r <= best_cand_nxt;
    out_scl_r   <= out_scl_nxt;
    out_psc_r   <= out_psc_nxt;
    out_baud_r  <= out_baud_nxt;
    out_exact_r <= out_exact_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_scaler_index    = out_scl_r;
  assign out_prescaler_index = out_psc_r;
  assign out_achieved_baud   = out_baud_r;
  assign out_exact_match     = out_exact_r;

endmodule

FILE: hw/rtl/sbps_chk.sv
`include "spi_baud_prescaler_search_top_defines.svh"

module sbps_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [31:0] in_module_clock,
  input logic [31:0] in_target_baud,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_scaler_index,
  input logic [1:0]  out_prescaler_index,
  input logic [30:0] out_achieved_baud,
  input logic        out_exact_match
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // a stalled result is held
  `SBPS_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_achieved_baud))
  // the search keeps the block busy for a long while after an item
  `SBPS_ASSERT_NEXT(a_busy_after_acc, in_acc, !in_ready ##1 !in_ready)
  // a new result only appears at the end of a busy period
  `SBPS_ASSERT_NOW(a_res_after_busy, $rose(out_valid), !$past(in_ready))
  // no result in the cycle after an item is taken with the output idle
  `SBPS_ASSERT_NEXT(a_no_instant_res, in_acc && !out_valid, !out_valid)

  logic unused_ok;
  assign unused_ok = ^{in_module_clock, in_target_baud, out_scaler_index,
                       out_prescaler_index, out_exact_match};

endmodule

bind spi_baud_prescaler_search_top sbps_chk u_sbps_chk (.*);

FILE: sim/spi_baud_prescaler_search_top_test.sv
`timescale 1ns / 100ps

module spi_baud_prescaler_search_top_test;

  typedef struct packed {
    logic [sbps_pkg::SclIdxW-1:0] scaler_idx;
    logic [sbps_pkg::PscIdxW-1:0] prescaler_idx;
    logic [sbps_pkg::BaudW-1:0]   baud;
    logic                         exact;
  } baud_choice_t;

  localparam logic [15:0] SCALER_DIVS [16] = '{
    16'd2, 16'd4, 16'd6, 16'd8, 16'd16, 16'd32, 16'd64, 16'd128,
    16'd256, 16'd512, 16'd1024, 16'd2048, 16'd4096, 16'd8192, 16'd16384, 16'd32768
  };
  localparam logic [2:0] PRESCALER_DIVS [4] = '{3'd2, 3'd3, 3'd5, 3'd7};
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam int ITEM_CYCLES = 2200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_module_clock = '0;
  logic [31:0] in_target_baud = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_scaler_index;
  logic [1:0]  out_prescaler_index;
  logic [30:0] out_achieved_baud;
  logic        out_exact_match;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  baud_choice_t pending_choices [$];

  spi_baud_prescaler_search_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_module_clock     (in_module_clock),
    .in_target_baud      (in_target_baud),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_scaler_index    (out_scaler_index),
    .out_prescaler_index (out_prescaler_index),
    .out_achieved_baud   (out_achieved_baud),
    .out_exact_match     (out_exact_match)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // first pair with the strictly smallest distance wins, scaler-major order
  function automatic baud_choice_t predict_prescaler_choice(input logic [31:0] clk_hz,
                                                            input logic [31:0] tgt);
    baud_choice_t best;
    logic [31:0]  best_diff;
    logic [31:0]  best_q;
    logic [31:0]  div;
    logic [31:0]  q;
    logic [31:0]  diff;
    logic         have;
    best = '0;
    best_diff = '0;
    best_q = '0;
    have = 1'b0;
    for (int s = 0; s < 16; s++) begin
      for (int p = 0; p < 4; p++) begin
        div = SCALER_DIVS[s] * PRESCALER_DIVS[p];
        q = clk_hz / div;
        diff = (q >= tgt) ? (q - tgt) : (tgt - q);
        if (!have || diff < best_diff) begin
          have = 1'b1;
          best_diff = diff;
          best_q = q;
          best.scaler_idx = s[sbps_pkg::SclIdxW-1:0];
          best.prescaler_idx = p[sbps_pkg::PscIdxW-1:0];
        end
      end
    end
    best.baud = best_q[sbps_pkg::BaudW-1:0];
    best.exact = (best_q == tgt);
    return best;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_v, act_v);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    baud_choice_t exp_c;
    if (rst_n && out_valid && out_ready) begin
      if (pending_choices.size() == 0) begin
        note_mismatch("unexpected result, scaler index", 32'd0, 32'(out_scaler_index));
      end else begin
        exp_c = pending_choices.pop_front();
        if (out_scaler_index !== exp_c.scaler_idx)
          note_mismatch("scaler index", 32'(exp_c.scaler_idx), 32'(out_scaler_index));
        if (out_prescaler_index !== exp_c.prescaler_idx)
          note_mismatch("prescaler index", 32'(exp_c.prescaler_idx),
                        32'(out_prescaler_index));
        if (out_achieved_baud !== exp_c.baud)
          note_mismatch("achieved baud", 32'(exp_c.baud), 32'(out_achieved_baud));
        if (out_exact_match !== exp_c.exact)
          note_mismatch("exact match", 32'(exp_c.exact), 32'(out_exact_match));
      end
    end
  end

  // valid is left high after acceptance; the next call lowers it or reloads it
  task automatic send_item(input logic [31:0] clk_hz, input logic [31:0] tgt);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_module_clock <= clk_hz;
    in_target_baud <= tgt;
    do @(posedge clk); while (!in_ready);
    pending_choices.push_back(predict_prescaler_choice(clk_hz, tgt));
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_choices.size() != 0) @(posedge clk);
  endtask

  // clock built so that one pair divides it to a chosen quotient
  task automatic send_exact_item(input int nudge);
    int          s;
    int          p;
    logic [31:0] div;
    logic [31:0] q;
    logic [31:0] rem;
    logic [32:0] sum;
    s = $urandom_range(0, 15);
    p = $urandom_range(0, 3);
    div = SCALER_DIVS[s] * PRESCALER_DIVS[p];
    q = $urandom_range(0, ALL_ONES / div);
    rem = $urandom_range(0, div - 1);
    sum = {1'b0, q * div} + {1'b0, rem};
    if (sum[32]) rem = '0;
    send_item(q * div + rem, q + nudge);
  endtask

  task automatic test_directed();
    send_item('0, '0);
    send_item('0, ALL_ONES);
    send_item(ALL_ONES, '0);
    send_item(ALL_ONES, ALL_ONES);
    send_item(ALL_ONES, 32'h7FFF_FFFF);
    send_item(32'h8000_0000, 32'd1);
    send_item(32'd3, 32'd0);
    send_item(32'd3, 32'd1);
    send_item(32'd4, 32'd1);
    send_item(32'd40, 32'd8);            // tie between 10 and 6, first pair kept
    send_item(32'd60, 32'd8);
    send_item(32'd50_000_000, 32'd12_500_000);
    send_item(32'd50_000_000, 32'd115_200);
    send_item(32'd50_000_000, 32'd9_600);
    send_item(32'd50_000_000, 32'd300);
    send_item(32'd120_000_000, 32'd1_000_000);
    send_item(32'd229_376, 32'd1);       // 32768 * 7 exactly
    send_item(32'd229_375, 32'd0);
    send_item(32'd100_000_000, 32'd1);
    send_item(32'hAAAA_AAAA, 32'h5555_5555);
    send_item(32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  task automatic test_random_mix(input int count);
    int unsigned kind;
    logic [31:0] clk_hz;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        send_exact_item((kind == 0) ? $urandom_range(0, 4) - 2 : 0);
      end else if (kind < 7) begin
        clk_hz = $urandom_range(1_000_000, 200_000_000);
        case ($urandom_range(0, 3))
          0:       send_item(clk_hz, 32'd9_600);
          1:       send_item(clk_hz, 32'd115_200);
          2:       send_item(clk_hz, 32'd1_000_000);
          default: send_item(clk_hz, $urandom_range(100, clk_hz / 4));
        endcase
      end else begin
        send_item($urandom, $urandom);
      end
    end
  endtask

  task automatic test_pause_for_results();
    send_exact_item(0);
    send_item($urandom, $urandom);
    hold_until_drained();
    send_exact_item(0);
    send_item(32'd48_000_000, 32'd57_600);
  endtask

  task automatic finish_run();
    int waited;
    hold_until_drained();
    waited = 0;
    while (pending_choices.size() != 0 && waited < 4 * ITEM_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (ITEM_CYCLES) @(posedge clk);
    if (pending_choices.size() != 0)
      note_mismatch("results still outstanding", 32'd0, pending_choices.size());
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 27;
    recv_idle_pct = 59;
    test_directed();
    test_random_mix(80);
    test_pause_for_results();

    send_idle_pct = 59;
    recv_idle_pct = 27;
    test_random_mix(90);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(90);

    finish_run();
  end

endmodule
